@@ src/sid_pkg.sv @@
// Shared types and constants for the software interrupt dispatcher.
// Used by sid_queue and soft_interrupt_dispatcher_core; depends on nothing.
`default_nettype none

package sid_pkg;

   localparam int LINE_COUNT_DEFAULT  = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 32;

   localparam int LINE_W = 5;
   localparam int WORD_W = 32;
   localparam int REQ_W  = 3;
   localparam int KIND_W = 2;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 104;

   // request codes
   localparam logic [REQ_W-1:0] REQ_RAISE   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SERVICE = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WORK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [WORD_W-1:0] ctx;
      logic [WORD_W-1:0] routine;
   } work_item_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/sid_queue.sv @@
// Ring queue of deferred work items with registered read data.
// Depends on sid_pkg for the item and status types.
`default_nettype none

module sid_queue
   import sid_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire work_item_type    push_item,
   input  wire logic             pop,
   output queue_status_type      status,
   output work_item_type         rd_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_item_type mem [QUEUE_DEPTH];
   work_item_type rd_item_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_next, wr_next;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign rd_next = ring_next(rd_ptr_ff);
   assign wr_next = ring_next(wr_ptr_ff);

   // one slot always stays empty
   assign status.empty    = (rd_ptr_ff == wr_ptr_ff);
   assign status.full     = (wr_next == rd_ptr_ff);
   assign status.one_left = (rd_next == wr_ptr_ff);

   assign rd_ptr_in = pop  ? rd_next : rd_ptr_ff;
   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;
   assign rd_item   = rd_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
      rd_item_ff <= mem[rd_ptr_ff];
   end

endmodule

`default_nettype wire

@@ src/soft_interrupt_dispatcher_core.sv @@
// Software interrupt dispatcher: pending/enable masks, sequencer and result register.
// Depends on sid_pkg and sid_queue.
`default_nettype none

// Raise, block, unblock and enqueue each give one acknowledge item on the
// rsp side, available the cycle after acceptance; a new request is taken once
// the result register is free (empty, or being taken on rsp_tready). A service
// request walks the enabled pending bits one line position per cycle, waiting
// at a set bit until the result register is free, up to the highest bit it
// must dispatch, then drains the work queue item by item: a registered queue
// read, then a load of the result register once it is free on rsp_tready.
// The block accepts no request while a service pass runs. The queue holds at
// most QUEUE_DEPTH-1 items; its storage is not cleared at reset.

module soft_interrupt_dispatcher_core
   import sid_pkg::*;
#(
   parameter int LINE_COUNT  = LINE_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [4:0] line_index, [36:5] line_mask, [68:37] routine_handle,
   // [100:69] context_word, [132:101] data_word, [135:133] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  wire logic [REQ_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] accepted, [1] accepted (copy), [6:2] line_number, [38:7] routine_out,
   // [70:39] context_out, [102:71] data_out, [103] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] result_kind
   output logic [KIND_W-1:0]          rsp_tuser,
   output logic                       rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_QREAD,
      ST_QEMIT
   } state_type;

   state_type state_ff, state_in;

   logic [LINE_COUNT-1:0] pending_ff, pending_in;
   logic [LINE_COUNT-1:0] enable_ff, enable_in;
   logic [LINE_COUNT-1:0] scan_ff, scan_in;
   logic [LINE_W-1:0]     idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic [LINE_W-1:0] rsp_line_ff, rsp_line_in;
   work_item_type     rsp_item_ff, rsp_item_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [LINE_W-1:0]     line_index;
   logic [LINE_COUNT-1:0] line_mask;
   work_item_type         req_item;
   logic [LINE_COUNT-1:0] go;
   logic [LINE_COUNT-1:0] raise_bit;
   logic [LINE_COUNT-1:0] scan_rest;
   logic                  req_fire;
   logic                  rsp_free;
   logic                  ok;
   logic                  push;
   logic                  pop;
   queue_status_type      qstat;
   work_item_type         q_item;

   assign line_index       = req_tdata[4:0];
   assign line_mask        = req_tdata[5 +: LINE_COUNT];
   assign req_item.routine = req_tdata[68:37];
   assign req_item.ctx     = req_tdata[100:69];
   assign req_item.data    = req_tdata[132:101];

   assign go        = pending_ff & enable_ff;
   assign raise_bit = LINE_COUNT'(1) << line_index;
   assign scan_rest = scan_ff >> 1;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   sid_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(req_item),
      .pop      (pop),
      .status   (qstat),
      .rd_item  (q_item)
   );

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      enable_in    = enable_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      ok           = 1'b0;
      push         = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_line_in  = '0;
               rsp_item_in  = '0;
               rsp_last_in  = 1'b1;
               case (req_tuser)
                  REQ_RAISE: begin
                     if (6'(line_index) < 6'(LINE_COUNT)) begin
                        ok         = !(|(pending_ff & raise_bit));
                        pending_in = pending_ff | raise_bit;
                     end
                  end
                  REQ_BLOCK: begin
                     enable_in = enable_ff & ~line_mask;
                  end
                  REQ_UNBLOCK: begin
                     ok        = |(pending_ff & line_mask & ~enable_ff);
                     enable_in = enable_ff | line_mask;
                  end
                  REQ_ENQUEUE: begin
                     if (!qstat.full) begin
                        push = 1'b1;
                        ok   = 1'b1;
                     end
                  end
                  REQ_SERVICE: begin
                     pending_in = pending_ff & ~go;
                     scan_in    = go;
                     idx_in     = '0;
                     if (go == '0) begin
                        if (qstat.empty) begin
                           rsp_kind_in = KIND_IDLE;
                        end else begin
                           rsp_valid_in = 1'b0;
                           state_in     = ST_QREAD;
                        end
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_acc_in = ok;
            end
         end
         ST_SCAN: begin
            // a zero bit is skipped without waiting; a set bit waits for the result slot
            if (!scan_ff[0] || rsp_free) begin
               if (scan_ff[0]) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_LINE;
                  rsp_acc_in   = 1'b0;
                  rsp_line_in  = idx_ff;
                  rsp_item_in  = '0;
                  rsp_last_in  = (scan_rest == '0) && qstat.empty;
               end
               scan_in = scan_rest;
               idx_in  = idx_ff + LINE_W'(1);
               if (scan_rest == '0) begin
                  state_in = qstat.empty ? ST_IDLE : ST_QREAD;
               end
            end
         end
         ST_QREAD: begin
            state_in = ST_QEMIT;
         end
         ST_QEMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WORK;
               rsp_acc_in   = 1'b0;
               rsp_line_in  = '0;
               rsp_item_in  = q_item;
               rsp_last_in  = qstat.one_left;
               pop          = 1'b1;
               state_in     = qstat.one_left ? ST_IDLE : ST_QREAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         enable_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      idx_ff      <= idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_line_ff <= rsp_line_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_item_ff.data, rsp_item_ff.ctx, rsp_item_ff.routine,
                        rsp_line_ff, rsp_acc_ff, rsp_acc_ff};

`ifndef SYNTHESIS
   a_scan_has_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_ff != '0)
      else $error("line scan running with no bits left");

   a_drain_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QREAD || state_ff == ST_QEMIT) |-> !qstat.empty)
      else $error("queue drain on an empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full && state_ff == ST_IDLE)
      else $error("queue written while full or busy");

   a_service_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == REQ_SERVICE |=> (pending_ff & enable_ff) == '0)
      else $error("enabled pending bits left after service");
`endif

endmodule

`default_nettype wire
